// ===== sv/ac_remote_frame_builder_top_defines.svh =====
// assertion macros shared by the frame builder modules
// expects clk and rst_n in the scope of the module that uses them
`ifndef AC_REMOTE_FRAME_BUILDER_TOP_DEFINES_SVH
`define AC_REMOTE_FRAME_BUILDER_TOP_DEFINES_SVH

// consequent checked in the same cycle
`define ACRFB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define ACRFB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/acrfb_pkg.sv =====
// types, constants and code tables for the remote frame builder
// no dependencies
`default_nettype none

package acrfb_pkg;

    localparam int FrameBytes = 13;
    localparam int QueueDepth = 2;
    localparam int PtrW       = $clog2(QueueDepth);
    localparam int CountW     = $clog2(QueueDepth + 1);

    localparam logic [3:0] LastIndex    = 4'd13;
    localparam logic [7:0] CustomerCode = 8'hA6;

    localparam logic [4:0] CapHourIn   = 5'd24;
    localparam logic [4:0] CapHourOut  = 5'd23;
    localparam logic [5:0] CapMinute   = 6'd59;

    localparam int FlagPower  = 0;
    localparam int FlagSleep  = 1;
    localparam int FlagHealth = 2;
    localparam int FlagB4Hi   = 3;
    localparam int FlagB12Lo  = 4;
    localparam int FlagB12Hi  = 5;
    localparam int FlagB8     = 6;
    localparam int FlagLight  = 7;

    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  temperature;
        logic [1:0]  fan_speed;
        logic [2:0]  vertical_swing;
        logic [2:0]  horizontal_swing;
        logic [1:0]  strength;
        logic [5:0]  position;
        logic [7:0]  feature_flags;
        logic [10:0] timer_time;
        logic [10:0] sleep_time;
        logic [4:0]  key_id;
    } settings_t;

    typedef struct packed {
        logic [3:0] byte_index;
        logic [7:0] byte_value;
        logic       last;
    } frame_byte_t;

    // frame bytes 0..12, checksum is added by the serializer
    typedef logic [FrameBytes-1:0][7:0] frame_t;

    function automatic logic [7:0] mode_code(input logic [2:0] m);
        logic [7:0] c;
        case (m)
            3'd0:    c = 8'h00;
            3'd1:    c = 8'h20;
            3'd2:    c = 8'h40;
            3'd3:    c = 8'h80;
            3'd4:    c = 8'hC0;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] fan_code(input logic [1:0] f);
        logic [7:0] c;
        case (f)
            2'd0:    c = 8'hA0;
            2'd1:    c = 8'h60;
            2'd2:    c = 8'h40;
            2'd3:    c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] vswing_code(input logic [2:0] v);
        logic [7:0] c;
        case (v)
            3'd0:    c = 8'h0C;
            3'd1:    c = 8'h00;
            3'd2:    c = 8'h01;
            3'd3:    c = 8'h03;
            3'd4:    c = 8'h02;
            3'd5:    c = 8'h0A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] hswing_code(input logic [2:0] h);
        logic [7:0] c;
        case (h)
            3'd0:    c = 8'h00;
            3'd1:    c = 8'h60;
            3'd2:    c = 8'h80;
            3'd3:    c = 8'hA0;
            3'd4:    c = 8'hC0;
            3'd5:    c = 8'hE0;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ac_remote_frame_builder_top.sv =====
// Remote frame builder: each accepted settings snapshot becomes a 14-byte
// air-conditioner remote frame, sent one byte per cycle on the frame_byte
// channel while frame_byte_ready is high, with byte_index 0..13 and last set
// on the checksum byte. Frames follow one another back to back while
// frame_byte_ready stays high and the next frame is already queued. The
// first byte passes through the front register, the two-frame queue, the
// serializer load and the output register. Snapshots are taken while
// earlier frames are still going out, until the queue of two frames and
// the front register are all full.
// depends on acrfb_pkg, acrfb_front, acrfb_queue and acrfb_back
`default_nettype none

module ac_remote_frame_builder_top (
    input  wire                    clk,
    input  wire                    rst_n,
    input  acrfb_pkg::settings_t   settings,
    input  wire                    settings_valid,
    output logic                   settings_ready,
    output acrfb_pkg::frame_byte_t frame_byte,
    output logic                   frame_byte_valid,
    input  wire                    frame_byte_ready
);

    acrfb_pkg::frame_t front_frame, queue_frame;
    logic              front_valid, front_ready;
    logic              queue_valid, queue_ready;

    acrfb_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .settings       (settings),
        .settings_valid (settings_valid),
        .settings_ready (settings_ready),
        .frame          (front_frame),
        .frame_valid    (front_valid),
        .frame_ready    (front_ready)
    );

    acrfb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_frame (front_frame),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .rd_frame (queue_frame),
        .rd_valid (queue_valid),
        .rd_ready (queue_ready)
    );

    acrfb_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .frame            (queue_frame),
        .frame_valid      (queue_valid),
        .frame_ready      (queue_ready),
        .frame_byte       (frame_byte),
        .frame_byte_valid (frame_byte_valid),
        .frame_byte_ready (frame_byte_ready)
    );

endmodule

`default_nettype wire

// ===== sv/acrfb_front.sv =====
// front end: takes a settings snapshot, classifies the timer case
// and builds frame bytes 0..12 into a register; uses acrfb_pkg
`default_nettype none

module acrfb_front (
    input  wire                 clk,
    input  wire                 rst_n,
    input  acrfb_pkg::settings_t settings,
    input  wire                 settings_valid,
    output logic                settings_ready,
    output acrfb_pkg::frame_t   frame,
    output logic                frame_valid,
    input  wire                 frame_ready
);

    typedef enum logic [2:0] {
        TM_NONE,
        TM_SLEEP,
        TM_ON_EARLIEST,
        TM_ON,
        TM_OFF
    } timer_case_t;

    acrfb_pkg::frame_t frame_reg, frame_next;
    logic              valid_reg, valid_next;
    timer_case_t       tcase;
    logic              power, sleep, panel, off_slot;
    logic [10:0]       timer_capped, sel_time;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [7:0]        flags;
    logic              fire;

    assign flags          = settings.feature_flags;
    assign power          = flags[acrfb_pkg::FlagPower];
    assign sleep          = flags[acrfb_pkg::FlagSleep];
    assign settings_ready = !valid_reg || frame_ready;
    assign fire           = settings_valid && settings_ready;

    always_comb
    begin
        if (settings.timer_time != 11'd0)
        begin
            if (power)
                tcase = sleep ? TM_ON_EARLIEST : TM_ON;
            else
                tcase = TM_OFF;
        end
        else
        begin
            tcase = sleep ? TM_SLEEP : TM_NONE;
        end
    end

    // hour 24 goes out as 23:59 in the TM_ON and TM_OFF cases
    assign timer_capped = (settings.timer_time[10:6] == acrfb_pkg::CapHourIn) ?
                          {acrfb_pkg::CapHourOut, acrfb_pkg::CapMinute} :
                          settings.timer_time;

    always_comb
    begin
        case (tcase)
            TM_SLEEP:       sel_time = settings.sleep_time;
            TM_ON_EARLIEST: sel_time = (settings.sleep_time <= settings.timer_time) ?
                                       settings.sleep_time : settings.timer_time;
            TM_ON:          sel_time = timer_capped;
            TM_OFF:         sel_time = timer_capped;
            default:        sel_time = 11'd0;
        endcase
    end

    assign hour     = sel_time[10:6];
    assign minute   = sel_time[5:0];
    assign panel    = (tcase == TM_SLEEP) || (tcase == TM_ON_EARLIEST) || (tcase == TM_ON);
    assign off_slot = (tcase == TM_OFF);

    always_comb
    begin
        frame_next     = '0;
        frame_next[0]  = acrfb_pkg::CustomerCode;
        frame_next[1]  = {settings.temperature, 4'h0}
                         + acrfb_pkg::vswing_code(settings.vertical_swing);
        frame_next[2]  = acrfb_pkg::hswing_code(settings.horizontal_swing);
        frame_next[3]  = ({settings.position, 2'b00}
                          + {6'b0, flags[acrfb_pkg::FlagHealth], 1'b0})
                         | {1'b0, off_slot,
                            (tcase == TM_ON_EARLIEST) || (tcase == TM_ON), 5'b0};
        frame_next[4]  = {flags[acrfb_pkg::FlagB4Hi], power, 6'b0};
        frame_next[5]  = acrfb_pkg::fan_code(settings.fan_speed)
                         + (panel ? {3'b0, hour} : 8'h00);
        frame_next[6]  = {settings.strength, 6'b0}
                         + (panel ? {2'b0, minute} : 8'h00);
        frame_next[7]  = acrfb_pkg::mode_code(settings.mode)
                         + (off_slot ? {3'b0, hour} : 8'h00);
        frame_next[8]  = {(tcase == TM_SLEEP) || (tcase == TM_ON_EARLIEST),
                          flags[acrfb_pkg::FlagB8], 6'b0}
                         + (off_slot ? {2'b0, minute} : 8'h00);
        frame_next[10] = {3'b0, flags[acrfb_pkg::FlagLight], 4'b0};
        frame_next[12] = ({1'b0, flags[acrfb_pkg::FlagB12Hi],
                           flags[acrfb_pkg::FlagB12Lo], 5'b0}
                          + {3'b0, settings.key_id}) | 8'h80;
    end

    always_comb
    begin
        if (fire)
            valid_next = 1'b1;
        else if (frame_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            frame_reg <= frame_next;
    end

    assign frame       = frame_reg;
    assign frame_valid = valid_reg;

endmodule

`default_nettype wire

// ===== sv/acrfb_queue.sv =====
// short frame queue between the front end and the serializer
// uses acrfb_pkg and the assertion macros header
`default_nettype none
`include "ac_remote_frame_builder_top_defines.svh"

module acrfb_queue (
    input  wire                clk,
    input  wire                rst_n,
    input  acrfb_pkg::frame_t  wr_frame,
    input  wire                wr_valid,
    output logic               wr_ready,
    output acrfb_pkg::frame_t  rd_frame,
    output logic               rd_valid,
    input  wire                rd_ready
);

    acrfb_pkg::frame_t                  mem [acrfb_pkg::QueueDepth];
    logic [acrfb_pkg::PtrW-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [acrfb_pkg::PtrW-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [acrfb_pkg::CountW-1:0]       count_reg, count_next;
    logic                               push, pop;

    assign wr_ready = (count_reg != acrfb_pkg::CountW'(acrfb_pkg::QueueDepth));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_frame = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_frame;
    end

    `ACRFB_ASSERT_SAME(a_count_bound, 1'b1,
        count_reg <= acrfb_pkg::CountW'(acrfb_pkg::QueueDepth), "queue count over depth")
    `ACRFB_ASSERT_NEXT(a_push_grows, push && !pop,
        count_reg == $past(count_reg) + 1'b1, "push did not grow the queue")
    `ACRFB_ASSERT_NEXT(a_pop_shrinks, pop && !push,
        count_reg == $past(count_reg) - 1'b1, "pop did not shrink the queue")

endmodule

`default_nettype wire

// ===== sv/acrfb_back.sv =====
// serializer: shifts out frame bytes 0..12 one per cycle while frame_byte_ready allows, and appends
// the running checksum as byte 13; uses acrfb_pkg and the macros header
`default_nettype none
`include "ac_remote_frame_builder_top_defines.svh"

module acrfb_back (
    input  wire                    clk,
    input  wire                    rst_n,
    input  acrfb_pkg::frame_t      frame,
    input  wire                    frame_valid,
    output logic                   frame_ready,
    output acrfb_pkg::frame_byte_t frame_byte,
    output logic                   frame_byte_valid,
    input  wire                    frame_byte_ready
);

    acrfb_pkg::frame_t      shift_reg, shift_next;
    acrfb_pkg::frame_byte_t out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   busy_reg, busy_next;
    logic [3:0]             idx_reg, idx_next;
    logic [7:0]             sum_reg, sum_next;
    logic [7:0]             cur_byte;
    logic                   advance, emit, finishing, pop;

    assign advance   = !out_valid_reg || frame_byte_ready;
    assign emit      = advance && busy_reg;
    assign finishing = (idx_reg == acrfb_pkg::LastIndex);
    // next frame loads in the same cycle the checksum goes out
    assign pop       = advance && frame_valid && (!busy_reg || finishing);
    assign cur_byte  = finishing ? sum_reg : shift_reg[0];

    always_comb
    begin
        shift_next     = shift_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        if (advance)
            out_valid_next = busy_reg;
        if (emit)
        begin
            out_next.byte_index = idx_reg;
            out_next.byte_value = cur_byte;
            out_next.last       = finishing;
            shift_next          = {8'h00, shift_reg[acrfb_pkg::FrameBytes-1:1]};
            sum_next            = sum_reg + cur_byte;
            idx_next            = idx_reg + 4'd1;
            if (finishing)
                busy_next = 1'b0;
        end
        if (pop)
        begin
            shift_next = frame;
            sum_next   = 8'h00;
            idx_next   = 4'd0;
            busy_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            busy_reg      <= 1'b0;
            idx_reg       <= 4'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        out_reg   <= out_next;
        sum_reg   <= sum_next;
    end

    assign frame_ready      = pop;
    assign frame_byte       = out_reg;
    assign frame_byte_valid = out_valid_reg;

    `ACRFB_ASSERT_SAME(a_last_index, out_valid_reg && out_reg.last,
        out_reg.byte_index == acrfb_pkg::LastIndex, "last flag off the checksum byte")
    `ACRFB_ASSERT_SAME(a_idx_range, busy_reg,
        idx_reg <= acrfb_pkg::LastIndex, "byte index past frame end")
    `ACRFB_ASSERT_NEXT(a_no_gap, out_valid_reg && frame_byte_ready && !out_reg.last,
        out_valid_reg, "gap inside a frame")

endmodule

`default_nettype wire
